>>> rtl/ibq_pkg.sv
// ---------------------------------------------------------------------------
// ibq_pkg: shared types and constants of the biquad cascade
// Coefficient register indexes, accumulator sizing, the control word format
// and the microprogram that sequences the shared multiply-accumulate datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ibq_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	// Largest section sum stays below 2^33 in magnitude; 36 bits leave margin.
	localparam int ACC_W     = 36;
	localparam int NUM_COEFS = 6;
	localparam int CFG_IDX_W = 3;
	localparam int UC_W      = 4;

	localparam int IN_SHIFT  = 7;
	localparam int W_SHIFT   = 15;
	localparam int Y_SHIFT   = W_SHIFT - IN_SHIFT;

	localparam logic [CFG_IDX_W-1:0] REG_B0      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1_HALF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A0      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1_HALF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2      = 3'd5;

	localparam logic [UC_W-1:0] STEP_SECTION = 4'd0;

	localparam logic signed [ACC_W-1:0] SAT_HI = 36'sd32767;
	localparam logic signed [ACC_W-1:0] SAT_LO = -36'sd32767;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_A0_X,
		MUL_A1_W1,
		MUL_A2_W2,
		MUL_B0_W,
		MUL_B1_W1,
		MUL_B2_W2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_SHR,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD2,
		ACC_SUB,
		ACC_SUB2
	} acc_op_t;

	typedef enum logic {
		SEQ_NEXT,
		SEQ_END_SECTION
	} seq_t;

	typedef struct packed {
		mul_sel_t        mul_sel;
		acc_op_t         acc_op;
		logic            wr_w;
		seq_t            seq;
		logic [UC_W-1:0] jump;
	} ctrl_word_t;

	localparam ctrl_word_t UC_NOP = '{MUL_NONE, ACC_HOLD, 1'b0, SEQ_NEXT, STEP_SECTION};

	// Microprogram of one section. The multiplier result is registered, so
	// each product is accumulated by the step after the one that started it.
	function automatic ctrl_word_t ucode(input logic [UC_W-1:0] step);
		ctrl_word_t cw;
		cw = UC_NOP;
		unique case (step)
			4'd0: cw.mul_sel = MUL_A0_X;
			4'd1: begin
				cw.mul_sel = MUL_A1_W1;
				cw.acc_op  = ACC_LOAD_SHR;
			end
			4'd2: begin
				cw.mul_sel = MUL_A2_W2;
				cw.acc_op  = ACC_SUB2;
			end
			4'd3: cw.acc_op = ACC_SUB;
			4'd4: cw.wr_w = 1'b1;
			4'd5: cw.mul_sel = MUL_B0_W;
			4'd6: begin
				cw.mul_sel = MUL_B1_W1;
				cw.acc_op  = ACC_LOAD;
			end
			4'd7: begin
				cw.mul_sel = MUL_B2_W2;
				cw.acc_op  = ACC_ADD2;
			end
			4'd8: cw.acc_op = ACC_ADD;
			4'd9: begin
				cw.seq  = SEQ_END_SECTION;
				cw.jump = STEP_SECTION;
			end
			default: cw = UC_NOP;
		endcase
		return cw;
	endfunction

	// Symmetric saturation to the 16-bit range without the most negative code.
	function automatic logic signed [SAMPLE_W-1:0] sat_sym(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_W-1:0];
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ibq_if.sv
// ---------------------------------------------------------------------------
// ibq_if: sample stream channels of the biquad cascade
// Valid/ready channels; a transaction completes when both are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface ibq_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface ibq_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> rtl/iir_biquad_cascade_df2.sv
// ---------------------------------------------------------------------------
// iir_biquad_cascade_df2: cascade of direct form II biquad sections
// Each sample runs through every section in turn; the block takes no new
// sample until the last section is done, a limit set by the ten microprogram
// steps per section on the one shared multiplier.
// A result waits in the output register while the next sample is accepted.
// Reset clears coefficients, delay lines, the sequencer and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module iir_biquad_cascade_df2 #(
	parameter int NUM_SECTIONS = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ibq_in_if.sink                       feed,
	ibq_out_if.source                    result,
	input  logic                         cfg_we,
	input  logic [ibq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ibq_pkg::COEF_W-1:0]    cfg_data
);
	import ibq_pkg::*;

	localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
	localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

	// Coefficient registers, shared by every section.
	logic signed [COEF_W-1:0]   coef_q [NUM_COEFS];

	// Per-section delay lines (w1 and w2).
	logic signed [SAMPLE_W-1:0] delay_one_q [NUM_SECTIONS];
	logic signed [SAMPLE_W-1:0] delay_two_q [NUM_SECTIONS];

	// Sequencer state.
	logic                       busy_q;
	logic [UC_W-1:0]            pc_q;
	logic [SEC_W-1:0]           sec_q;
	ctrl_word_t                 ctrl;

	// Datapath registers.
	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] w_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;

	// Output register.
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_data_q;

	logic                       accept;
	logic                       end_step;
	logic                       last_sec;
	logic                       out_free;
	logic                       stall;
	logic                       advance;
	logic                       finish;
	logic signed [SAMPLE_W-1:0] w1;
	logic signed [SAMPLE_W-1:0] w2;
	logic signed [COEF_W-1:0]   mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    acc_d;
	logic signed [SAMPLE_W-1:0] y_sat;

	// ------------------------------------------------------------------
	// Configuration writes. Indexes past the last register are dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index <= REG_A2)) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Microcode sequencer. The step counter walks the section program;
	// the last step either jumps back for the next section or, for the
	// final section, hands the sample to the output register. If that
	// register still holds an untaken result, the last step waits.
	// ------------------------------------------------------------------
	assign ctrl     = ucode(pc_q);
	assign accept   = feed.valid && feed.ready;
	assign end_step = busy_q && (ctrl.seq == SEQ_END_SECTION);
	assign last_sec = (sec_q == LAST_SEC);
	assign out_free = !out_valid_q || result.ready;
	assign stall    = end_step && last_sec && !out_free;
	assign advance  = busy_q && !stall;
	assign finish   = end_step && last_sec && out_free;

	assign feed.ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_SECTION;
			sec_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= STEP_SECTION;
			sec_q  <= '0;
		end else if (advance) begin
			if (end_step) begin
				pc_q <= ctrl.jump;
				if (last_sec) begin
					busy_q <= 1'b0;
					sec_q  <= '0;
				end else begin
					sec_q <= sec_q + 1'b1;
				end
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath: operand selection, one registered 16x16 multiplier and a
	// 36-bit accumulator. The a0 product of the input is shifted right by
	// seven before it starts the feedback sum; a1 and b1 products are
	// doubled because the registers hold half the coefficient.
	// ------------------------------------------------------------------
	assign w1 = delay_one_q[sec_q];
	assign w2 = delay_two_q[sec_q];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul_sel)
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MUL_A0_X: begin
				mul_a = coef_q[REG_A0];
				mul_b = x_q;
			end
			MUL_A1_W1: begin
				mul_a = coef_q[REG_A1_HALF];
				mul_b = w1;
			end
			MUL_A2_W2: begin
				mul_a = coef_q[REG_A2];
				mul_b = w2;
			end
			MUL_B0_W: begin
				mul_a = coef_q[REG_B0];
				mul_b = w_q;
			end
			MUL_B1_W1: begin
				mul_a = coef_q[REG_B1_HALF];
				mul_b = w1;
			end
			MUL_B2_W2: begin
				mul_a = coef_q[REG_B2];
				mul_b = w2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

	always_comb begin
		acc_d = acc_q;
		unique case (ctrl.acc_op)
			ACC_HOLD:     acc_d = acc_q;
			ACC_LOAD_SHR: acc_d = prod_ext >>> IN_SHIFT;
			ACC_LOAD:     acc_d = prod_ext;
			ACC_ADD:      acc_d = acc_q + prod_ext;
			ACC_ADD2:     acc_d = acc_q + (prod_ext <<< 1);
			ACC_SUB:      acc_d = acc_q - prod_ext;
			ACC_SUB2:     acc_d = acc_q - (prod_ext <<< 1);
			default:      acc_d = acc_q;
		endcase
	end

	assign y_sat = sat_sym(acc_q >>> Y_SHIFT);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= feed.sample_in;
		end else if (advance && end_step) begin
			// The section output becomes the next section's input.
			x_q <= y_sat;
		end
		if (advance) begin
			prod_q <= mul_a * mul_b;
			acc_q  <= acc_d;
			if (ctrl.wr_w) begin
				w_q <= sat_sym(acc_q >>> W_SHIFT);
			end
		end
		if (finish) begin
			out_data_q <= y_sat;
		end
	end

	// Delay line shift at the end of each section.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SECTIONS; i++) begin
				delay_one_q[i] <= '0;
				delay_two_q[i] <= '0;
			end
		end else if (advance && end_step) begin
			delay_two_q[sec_q] <= delay_one_q[sec_q];
			delay_one_q[sec_q] <= w_q;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;

endmodule

`default_nettype wire

>>> rtl/ibq_checker.sv
// ---------------------------------------------------------------------------
// ibq_checker: port-level checks of the biquad cascade
// Watches the stream channels and flags sequencing and output-range slips.
// ---------------------------------------------------------------------------
`default_nettype none

module ibq_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sample_out
);

	// A sample in work blocks further input transactions.
	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready
	) else $error("input accepted again right after a transaction");

	// A result needs the whole program; it never rises right after an input transaction.
	a_no_instant_result: assert property (
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready)
	) else $error("result appeared right after an input transaction");

	// Saturation is symmetric: the most negative code never leaves the block.
	a_sym_range: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_out != 16'sh8000)
	) else $error("result holds the most negative code");

	// A stalled result holds.
	a_out_hold: assert property (
		@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_out))
	) else $error("stalled result changed");

endmodule

bind iir_biquad_cascade_df2 ibq_checker u_ibq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (feed.valid),
	.in_ready   (feed.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.sample_out (result.sample_out)
);

`default_nettype wire

>>> tb/sv/ibq_cascade_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ibq_cascade_checker: sample prediction and result checking for the cascade
// Watches the coefficient write port and both sample channels. Each accepted
// input sample is run through a bit-true model of the direct form II biquad
// cascade. The result is queued and compared against the next output
// transaction.
// ---------------------------------------------------------------------------

module ibq_cascade_checker #(
	parameter int NUM_SECTIONS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [ibq_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [ibq_pkg::SAMPLE_W-1:0] out_sample,
	input  logic                                cfg_we,
	input  logic [ibq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ibq_pkg::COEF_W-1:0]          cfg_data,
	output int                                  errors,
	output int                                  pending
);

	import ibq_pkg::*;

	logic signed [COEF_W-1:0]   coef [NUM_COEFS];
	logic signed [SAMPLE_W-1:0] w_last [NUM_SECTIONS];
	logic signed [SAMPLE_W-1:0] w_prev [NUM_SECTIONS];
	logic signed [SAMPLE_W-1:0] expected_samples [$];

	function automatic logic signed [SAMPLE_W-1:0] saturate16(input longint v);
		if (v > 32767) begin
			return 16'sd32767;
		end
		if (v < -32767) begin
			return -16'sd32767;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// Runs one sample through every section and advances the delay lines.
	function automatic logic signed [SAMPLE_W-1:0] filter_sample(
		input logic signed [SAMPLE_W-1:0] x_in
	);
		longint                     x;
		longint                     acc;
		logic signed [SAMPLE_W-1:0] w;
		x = x_in;
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			acc = (longint'(coef[REG_A0]) * x) >>> IN_SHIFT;
			acc = acc - 2 * longint'(coef[REG_A1_HALF]) * longint'(w_last[s]);
			acc = acc - longint'(coef[REG_A2]) * longint'(w_prev[s]);
			w   = saturate16(acc >>> W_SHIFT);
			acc = longint'(coef[REG_B0]) * longint'(w)
				+ 2 * longint'(coef[REG_B1_HALF]) * longint'(w_last[s])
				+ longint'(coef[REG_B2]) * longint'(w_prev[s]);
			w_prev[s] = w_last[s];
			w_last[s] = w;
			x = saturate16(acc >>> Y_SHIFT);
		end
		return x[SAMPLE_W-1:0];
	endfunction

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef[i] = '0;
			end
			for (int s = 0; s < NUM_SECTIONS; s++) begin
				w_last[s] = '0;
				w_prev[s] = '0;
			end
			expected_samples.delete();
			pending <= 0;
		end else begin
			// Outputs first: a result can never belong to a sample accepted at
			// the same edge.
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample_out transaction, got %0d",
						$time, out_sample);
					errors <= errors + 1;
				end else begin
					want = expected_samples.pop_front();
					if (out_sample !== want) begin
						$display("%0t: sample_out mismatch, expected %0d, got %0d",
							$time, want, out_sample);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_samples.push_back(filter_sample(in_sample));
			end
			// Writes to indexes past the last coefficient are dropped.
			if (cfg_we && cfg_index < NUM_COEFS) begin
				coef[cfg_index] = cfg_data;
			end
			pending <= expected_samples.size();
		end
	end

endmodule

>>> tb/sv/tb_iir_biquad_cascade_df2.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_iir_biquad_cascade_df2: testbench of the biquad cascade
// Programs several coefficient sets, from all-zero and full-scale extremes to
// random stable and unstable filters, and streams samples through the block
// with random bursts on the input and random backpressure on the output. A
// checker instance predicts every result and counts mismatches.
// ---------------------------------------------------------------------------

module tb_iir_biquad_cascade_df2;

	import ibq_pkg::*;

	localparam int NUM_SECTIONS = 2;
	// Time the block needs for one sample, scaled by the number of sections.
	localparam int LATENCY      = 10 * NUM_SECTIONS;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RAND_PHASES  = 9;
	localparam int PHASE_ITEMS  = 50;

	// Indexes that decode to no coefficient; writes there must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [CFG_IDX_W-1:0] COEF_REGS [NUM_COEFS] = '{
		REG_B0, REG_B1_HALF, REG_B2, REG_A0, REG_A1_HALF, REG_A2
	};

	typedef logic signed [COEF_W-1:0] coef_set_t [NUM_COEFS];

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data = '0;

	int errors;
	int pending;
	int cycle_count = 0;
	int burst_left = 0;

	ibq_in_if  feed_ch ();
	ibq_out_if result_ch ();

	iir_biquad_cascade_df2 #(
		.NUM_SECTIONS(NUM_SECTIONS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ibq_cascade_checker #(
		.NUM_SECTIONS(NUM_SECTIONS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(feed_ch.valid),
		.in_ready(feed_ch.ready),
		.in_sample(feed_ch.sample_in),
		.out_valid(result_ch.valid),
		.out_ready(result_ch.ready),
		.out_sample(result_ch.sample_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always #2 clk = ~clk;

	// Every input of the block holds a known value from time zero.
	initial begin
		feed_ch.valid     = 1'b0;
		feed_ch.sample_in = '0;
		result_ch.ready   = 1'b0;
	end

	// The watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Output backpressure. The receiver switches between a few stall styles
	// at random intervals: always ready, a coin flip, rarely ready, and a
	// fixed periodic stall. Intervals that are always ready give stretches
	// where the block runs at full rate.
	int stall_mode = 0;
	int mode_left = 0;
	int stall_period = 8;
	int stall_len = 3;
	int stall_phase = 0;

	always @(negedge clk) begin
		logic next_ready;
		if (mode_left == 0) begin
			stall_mode   = $urandom_range(0, 3);
			mode_left    = $urandom_range(50, 400);
			stall_period = $urandom_range(2, 30);
			stall_len    = $urandom_range(1, stall_period - 1);
			stall_phase  = 0;
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: begin
				next_ready = 1'b1;
			end
			1: begin
				next_ready = 1'($urandom_range(0, 1));
			end
			2: begin
				next_ready = ($urandom_range(0, 5) == 0);
			end
			default: begin
				next_ready  = (stall_phase >= stall_len);
				stall_phase = (stall_phase + 1) % stall_period;
			end
		endcase
		result_ch.ready <= next_ready;
	end

	// Writes all six coefficients on consecutive cycles. With poke_spare set,
	// the two unused indexes get random data as well, which the block must
	// drop. The write enable is lowered only after the last write.
	task automatic load_coefs(input coef_set_t c, input bit poke_spare);
		for (int i = 0; i < NUM_COEFS; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= COEF_REGS[i];
			cfg_data  <= c[i];
			@(negedge clk);
		end
		if (poke_spare) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_SPARE_LO;
			cfg_data  <= COEF_W'($urandom);
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= REG_SPARE_HI;
			cfg_data  <= COEF_W'($urandom);
			@(negedge clk);
		end
		// Idle cycles carry junk on the index and data lines.
		cfg_we    <= 1'b0;
		cfg_index <= CFG_IDX_W'($urandom);
		cfg_data  <= COEF_W'($urandom);
		@(negedge clk);
	endtask

	// Offers one sample and returns at the falling edge after the transaction.
	// The sender runs in bursts; before each burst it may drop valid for a
	// random gap, during which the data lines carry junk.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
			if (gap > 0) begin
				feed_ch.valid     <= 1'b0;
				feed_ch.sample_in <= SAMPLE_W'($urandom);
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		feed_ch.valid     <= 1'b1;
		feed_ch.sample_in <= s;
		do begin
			@(posedge clk);
		end while (!feed_ch.ready);
		@(negedge clk);
	endtask

	// Stops offering samples and waits until every predicted result has come
	// back. Each sample yields exactly one result, so the block is idle then.
	task automatic drain();
		feed_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	// Picks a coefficient set. Stable sets keep the feedback terms small so
	// the output tracks the input instead of sitting at the rails; wild sets
	// draw heavily on the extremes and saturate most of the time.
	function automatic coef_set_t make_coefs(input bit stable);
		coef_set_t c;
		for (int i = 0; i < NUM_COEFS; i++) begin
			case ($urandom_range(0, 9))
				0: c[i] = -16'sd32768;
				1: c[i] = 16'sd32767;
				2: c[i] = '0;
				3, 4, 5: c[i] = COEF_W'($urandom);
				default: c[i] = COEF_W'($urandom_range(0, 1023) - 512);
			endcase
		end
		if (stable) begin
			c[REG_A0]      = COEF_W'($urandom_range(0, 65535) - 32768);
			c[REG_A1_HALF] = COEF_W'($urandom_range(0, 12000) - 6000);
			c[REG_A2]      = COEF_W'($urandom_range(0, 16000) - 8000);
		end
		return c;
	endfunction

	// Full-range words most of the time, with the rails and small values mixed
	// in so every input bit toggles and quiet signals are exercised too.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2, 3: return SAMPLE_W'($urandom_range(0, 255) - 128);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		coef_set_t cs;
		logic signed [SAMPLE_W-1:0] edge_samples [7];

		// Reset goes low through a nonblocking write, so every process is
		// already waiting on its falling edge when it lands.
		arst_n <= 1'b0;

		edge_samples = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, -16'sd1,
			16'sd32767, -16'sd32768};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Coefficients come out of reset as zero, so everything filters to
		// zero, even the rails.
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd1234);
		drain();

		// Every coefficient at the positive rail.
		cs = '{default: 16'sd32767};
		load_coefs(cs, 1'b0);
		foreach (edge_samples[i]) begin
			send_sample(edge_samples[i]);
		end
		drain();

		// Every coefficient at the negative rail.
		cs = '{default: -16'sd32768};
		load_coefs(cs, 1'b0);
		foreach (edge_samples[i]) begin
			send_sample(edge_samples[i]);
		end
		drain();

		// Maximum gain with positive feedback: the state and output run into
		// saturation in both directions. The spare indexes are written here
		// too and must leave this set untouched.
		cs = '{default: 16'sd32767};
		cs[REG_A1_HALF] = -16'sd32768;
		cs[REG_A2]      = -16'sd32768;
		load_coefs(cs, 1'b1);
		repeat (4) send_sample(16'sd32767);
		repeat (4) send_sample(-16'sd32768);
		drain();

		// Random part: alternating stable and wild coefficient sets, new ones
		// loaded only while the block is idle.
		for (int p = 0; p < RAND_PHASES; p++) begin
			cs = make_coefs(p % 2 == 0);
			load_coefs(cs, $urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Once per phase the sender holds off until the block has
				// emptied completely, then resumes on the same filter state.
				if (n == PHASE_ITEMS / 2) begin
					drain();
				end
				send_sample(pick_sample());
			end
			drain();
		end

		repeat (2 * LATENCY) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
